// ----- src/floppy_controller_command_port_defines.svh -----
// Assertion macros shared by the floppy controller command port RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef FLOPPY_CONTROLLER_COMMAND_PORT_DEFINES_SVH
`define FLOPPY_CONTROLLER_COMMAND_PORT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FDC_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FDC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fdc_pkg.sv -----
// Package for the floppy controller command port: geometry constants, codes, types.
// No dependencies; imported by the interfaces and all modules.
package fdc_pkg;

    localparam int SECTOR_BYTES      = 128;
    localparam int TRACK_COUNT       = 77;
    localparam int SECTORS_PER_TRACK = 26;
    localparam int DRIVE_COUNT       = 4;
    localparam int ADDR_W            = $clog2(SECTOR_BYTES);

    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 7;
    localparam int REQ_W    = 2;
    localparam int DRIVE_W  = 2;
    localparam int LSECT_W  = 11;
    localparam int TRACK_W  = 7;
    localparam int SECT_W   = 5;
    localparam int MASK_W   = 4;
    localparam int REGIDX_W = 1;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [REQ_W-1:0]   req_t;
    typedef logic [DRIVE_W-1:0] drive_t;
    typedef logic [LSECT_W-1:0] lsect_t;
    typedef logic [TRACK_W-1:0] track_t;
    typedef logic [SECT_W-1:0]  sect_t;
    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [REGIDX_W-1:0] regidx_t;

    // Bus item kinds
    localparam cmd_t ITEM_LATCH = 3'd0;
    localparam cmd_t ITEM_CMD   = 3'd1;
    localparam cmd_t ITEM_READ  = 3'd2;
    localparam cmd_t ITEM_FILL  = 3'd3;
    localparam cmd_t ITEM_DRAIN = 3'd4;

    // Command opcodes
    localparam byte_t OP_STATUS  = 8'h00;
    localparam byte_t OP_READ    = 8'h03;
    localparam byte_t OP_WRITE   = 8'h05;
    localparam byte_t OP_CHECK   = 8'h07;
    localparam byte_t OP_SEEK    = 8'h09;
    localparam byte_t OP_CLEAR   = 8'h0b;
    localparam byte_t OP_RESTORE = 8'h0d;
    localparam byte_t OP_SETTRK  = 8'h11;
    localparam byte_t OP_SELECT  = 8'h21;
    localparam byte_t OP_WRBUF   = 8'h31;
    localparam byte_t OP_RDBUF   = 8'h40;
    localparam byte_t OP_SHIFT   = 8'h41;
    localparam byte_t OP_SRESET  = 8'h81;

    // Error bits
    localparam byte_t ERR_BUSY   = 8'h01;
    localparam byte_t ERR_SEEK   = 8'h02;
    localparam byte_t ERR_CRC    = 8'h08;
    localparam byte_t ERR_WPROT  = 8'h10;
    localparam byte_t ERR_NREADY = 8'h20;

    // Media requests
    localparam req_t REQ_NONE  = 2'd0;
    localparam req_t REQ_READ  = 2'd1;
    localparam req_t REQ_WRITE = 2'd2;

    // Configuration register indexes
    localparam regidx_t REG_PRESENT  = 1'd0;
    localparam regidx_t REG_WRITABLE = 1'd1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } ctl_t;

endpackage

// ----- src/fdc_if.sv -----
// Handshake channel interfaces: bus/media items in, result beats out.
// Depends on fdc_pkg.
interface fdc_item_if
    import fdc_pkg::*;
;
    logic   valid;
    logic   ready;
    cmd_t   cmd;
    byte_t  data;
    index_t byte_index;

    modport source (output valid, cmd, data, byte_index, input ready);
    modport sink   (input valid, cmd, data, byte_index, output ready);
endinterface

interface fdc_result_if
    import fdc_pkg::*;
;
    logic   valid;
    logic   ready;
    byte_t  read_data;
    req_t   media_request;
    drive_t media_drive;
    lsect_t media_sector;

    modport source (output valid, read_data, media_request, media_drive, media_sector,
                    input ready);
    modport sink   (input valid, read_data, media_request, media_drive, media_sector,
                    output ready);
endinterface

// ----- src/fdc_ctrl.sv -----
// Controller state machine: takes an item beat, then executes it into the result register.
// Depends on fdc_pkg and the assertion macro header.
`include "floppy_controller_command_port_defines.svh"

module fdc_ctrl
    import fdc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output ctl_t ctl
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        ctl.capture    = 1'b0;
        ctl.exec       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // hold until the result register frees up
                if (slot_free)
                begin
                    ctl.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    `FDC_ASSERT_IMPL(a_exec_slot, clk, rst_n, ctl.exec, !out_valid_reg || out_ready, "exec over live result")
    `FDC_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_reg == ST_EXEC, "accept lost")
    `FDC_ASSERT_NEXT(a_exec_valid, clk, rst_n, ctl.exec, out_valid_reg, "result not presented")

endmodule

// ----- src/fdc_dp.sv -----
// Datapath: controller registers, per-drive tracks, error bits, both sector buffers.
// Depends on fdc_pkg and the assertion macro header; driven by fdc_ctrl strobes.
`include "floppy_controller_command_port_defines.svh"

module fdc_dp
    import fdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  ctl_t    ctl,
    input  logic    wr_en,
    input  regidx_t reg_index,
    input  mask_t   wr_data,
    input  cmd_t    cmd,
    input  byte_t   data,
    input  index_t  byte_index,
    output byte_t   read_data,
    output req_t    media_request,
    output drive_t  media_drive,
    output lsect_t  media_sector
);

    mask_t  present_reg, writable_reg;
    track_t drive_track_reg [DRIVE_COUNT];
    track_t drive_track_next[DRIVE_COUNT];
    drive_t drive_reg, drive_next;
    sect_t  sector_reg, sector_next;
    byte_t  target_reg, target_next;
    byte_t  out_latch_reg, out_latch_next;
    byte_t  in_latch_reg, in_latch_next;
    byte_t  err_reg, err_next;
    byte_t  rd_ptr_reg, rd_ptr_next;
    byte_t  wr_ptr_reg, wr_ptr_next;
    byte_t  wr_fill_reg, wr_fill_next;

    cmd_t   cmd_reg;
    byte_t  data_reg;
    index_t idx_reg;

    byte_t  rd_mem [SECTOR_BYTES];
    byte_t  wr_mem [SECTOR_BYTES];
    logic [SECTOR_BYTES-1:0] rd_vld_reg, wr_vld_reg;
    byte_t  rd_q_reg, wr_q_reg;
    logic   rd_qv_reg, wr_qv_reg;

    byte_t  read_data_reg, read_data_next;
    req_t   req_reg, req_next;
    drive_t mdrive_reg, mdrive_next;
    lsect_t msector_reg, msector_next;

    logic   drv_ready, drv_writable, place_ok, soft_clr, fill_we, wrbuf_we;
    byte_t  place_err, status, rd_step, rd_view, rd_sel;
    track_t cur_track;
    lsect_t lsect;
    logic [ADDR_W-1:0] rd_addr;

    assign cur_track    = drive_track_reg[drive_reg];
    assign drv_ready    = (32'(drive_reg) < DRIVE_COUNT) && present_reg[drive_reg];
    assign drv_writable = writable_reg[drive_reg];
    assign lsect        = LSECT_W'(cur_track) * LSECT_W'(SECTORS_PER_TRACK)
                          + LSECT_W'(sector_reg) - LSECT_W'(1);
    assign rd_step      = (rd_ptr_reg < BYTE_W'(SECTOR_BYTES)) ? rd_ptr_reg + 8'd1
                                                                : rd_ptr_reg;
    assign rd_sel       = (cmd == ITEM_CMD && data == OP_SHIFT) ? rd_step : rd_ptr_reg;
    assign rd_addr      = rd_sel[ADDR_W-1:0];
    assign rd_view      = (data_reg == OP_SHIFT) ? rd_step : rd_ptr_reg;

    always_comb
    begin
        place_err = '0;
        if (!drv_ready)
            place_err = ERR_NREADY;
        else if (cur_track >= TRACK_W'(TRACK_COUNT))
            place_err = ERR_SEEK | ERR_CRC;
        else if (sector_reg == '0 || sector_reg > SECT_W'(SECTORS_PER_TRACK))
            place_err = ERR_CRC;
        place_ok = (place_err == '0);
    end

    always_comb
    begin
        status = err_reg & ~ERR_BUSY;
        if (!drv_ready)
            status = status | ERR_NREADY;
        else if (!drv_writable)
            status = status | ERR_WPROT;
    end

    always_comb
    begin
        drive_track_next = drive_track_reg;
        drive_next       = drive_reg;
        sector_next      = sector_reg;
        target_next      = target_reg;
        out_latch_next   = out_latch_reg;
        in_latch_next    = in_latch_reg;
        err_next         = err_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        wr_fill_next     = wr_fill_reg;
        read_data_next   = '0;
        req_next         = REQ_NONE;
        mdrive_next      = '0;
        msector_next     = '0;
        soft_clr         = 1'b0;
        fill_we          = 1'b0;
        wrbuf_we         = 1'b0;
        if (ctl.exec)
        begin
            case (cmd_reg)
                ITEM_LATCH:
                    out_latch_next = data_reg;
                ITEM_READ:
                    read_data_next = in_latch_reg;
                ITEM_FILL:
                    fill_we = (32'(idx_reg) < SECTOR_BYTES);
                ITEM_DRAIN:
                    if (32'(idx_reg) < SECTOR_BYTES && wr_qv_reg)
                        read_data_next = wr_q_reg;
                ITEM_CMD:
                begin
                    case (data_reg)
                        OP_STATUS:
                            in_latch_next = status;
                        OP_READ:
                        begin
                            err_next = err_reg | place_err;
                            if (place_ok)
                            begin
                                req_next     = REQ_READ;
                                mdrive_next  = drive_reg;
                                msector_next = lsect;
                                rd_ptr_next  = '0;
                            end
                        end
                        OP_WRITE:
                        begin
                            err_next = err_reg | place_err;
                            if (place_ok)
                            begin
                                if (!drv_writable)
                                    err_next = err_reg | ERR_WPROT | ERR_NREADY;
                                else if (wr_fill_reg < BYTE_W'(SECTOR_BYTES))
                                    err_next = err_reg | ERR_CRC;
                                else
                                begin
                                    req_next     = REQ_WRITE;
                                    mdrive_next  = drive_reg;
                                    msector_next = lsect;
                                    wr_ptr_next  = '0;
                                end
                            end
                        end
                        OP_CHECK:
                            err_next = err_reg | place_err;
                        OP_SEEK:
                        begin
                            if (!drv_ready)
                                err_next = err_reg | ERR_NREADY;
                            else if (target_reg >= BYTE_W'(TRACK_COUNT))
                                err_next = err_reg | ERR_SEEK | ERR_CRC;
                            else
                                drive_track_next[drive_reg] = target_reg[TRACK_W-1:0];
                        end
                        OP_CLEAR:
                            err_next = '0;
                        OP_RESTORE:
                        begin
                            if (!drv_ready)
                                err_next = err_reg | ERR_NREADY;
                            drive_track_next[drive_reg] = '0;
                        end
                        OP_SETTRK:
                            target_next = out_latch_reg;
                        OP_SELECT:
                        begin
                            drive_next  = out_latch_reg[7:6];
                            sector_next = out_latch_reg[SECT_W-1:0];
                        end
                        OP_WRBUF:
                        begin
                            if (wr_ptr_reg < BYTE_W'(SECTOR_BYTES))
                            begin
                                wrbuf_we     = 1'b1;
                                wr_ptr_next  = wr_ptr_reg + 8'd1;
                                wr_fill_next = wr_ptr_reg + 8'd1;
                            end
                            else
                                err_next = err_reg | ERR_CRC;
                        end
                        OP_RDBUF, OP_SHIFT:
                        begin
                            rd_ptr_next = rd_view;
                            if (rd_view < BYTE_W'(SECTOR_BYTES))
                                in_latch_next = rd_qv_reg ? rd_q_reg : '0;
                            else
                                in_latch_next = 8'hff;
                        end
                        OP_SRESET:
                        begin
                            soft_clr       = 1'b1;
                            drive_next     = '0;
                            sector_next    = SECT_W'(1);
                            target_next    = '0;
                            out_latch_next = '0;
                            in_latch_next  = '0;
                            err_next       = '0;
                            rd_ptr_next    = '0;
                            wr_ptr_next    = '0;
                            wr_fill_next   = '0;
                        end
                        default:
                            err_next = err_reg;
                    endcase
                end
                default:
                    read_data_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            writable_reg  <= '0;
            for (int i = 0; i < DRIVE_COUNT; i++)
                drive_track_reg[i] <= '0;
            drive_reg     <= '0;
            sector_reg    <= SECT_W'(1);
            target_reg    <= '0;
            out_latch_reg <= '0;
            in_latch_reg  <= '0;
            err_reg       <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            wr_fill_reg   <= '0;
            rd_vld_reg    <= '0;
            wr_vld_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (reg_index)
                    REG_PRESENT:  present_reg  <= wr_data;
                    REG_WRITABLE: writable_reg <= wr_data;
                    default:      present_reg  <= present_reg;
                endcase
            end
            drive_track_reg <= drive_track_next;
            drive_reg       <= drive_next;
            sector_reg      <= sector_next;
            target_reg      <= target_next;
            out_latch_reg   <= out_latch_next;
            in_latch_reg    <= in_latch_next;
            err_reg         <= err_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            wr_fill_reg     <= wr_fill_next;
            if (soft_clr)
            begin
                rd_vld_reg <= '0;
                wr_vld_reg <= '0;
            end
            else
            begin
                if (fill_we)
                    rd_vld_reg[idx_reg[ADDR_W-1:0]] <= 1'b1;
                if (wrbuf_we)
                    wr_vld_reg[wr_ptr_reg[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
            rd_mem[idx_reg[ADDR_W-1:0]] <= data_reg;
        if (wrbuf_we)
            wr_mem[wr_ptr_reg[ADDR_W-1:0]] <= out_latch_reg;
        if (ctl.capture)
        begin
            cmd_reg   <= cmd;
            data_reg  <= data;
            idx_reg   <= byte_index;
            rd_q_reg  <= rd_mem[rd_addr];
            rd_qv_reg <= rd_vld_reg[rd_addr];
            wr_q_reg  <= wr_mem[byte_index[ADDR_W-1:0]];
            wr_qv_reg <= wr_vld_reg[byte_index[ADDR_W-1:0]];
        end
        if (ctl.exec)
        begin
            read_data_reg <= read_data_next;
            req_reg       <= req_next;
            mdrive_reg    <= mdrive_next;
            msector_reg   <= msector_next;
        end
    end

    assign read_data     = read_data_reg;
    assign media_request = req_reg;
    assign media_drive   = mdrive_reg;
    assign media_sector  = msector_reg;

    `FDC_ASSERT_IMPL(a_rd_ptr_bound, clk, rst_n, 1'b1, rd_ptr_reg <= BYTE_W'(SECTOR_BYTES), "read pointer past buffer")
    `FDC_ASSERT_IMPL(a_wr_ptr_bound, clk, rst_n, 1'b1, wr_ptr_reg <= BYTE_W'(SECTOR_BYTES), "write pointer past buffer")
    `FDC_ASSERT_NEXT(a_req_only_cmd, clk, rst_n, ctl.exec && cmd_reg != ITEM_CMD, media_request == REQ_NONE, "request from non-command beat")

endmodule

// ----- src/floppy_controller_command_port.sv -----
// Floppy controller command port: every accepted item beat returns exactly one result
// beat. One beat at a time is between capture and execution: the capture step latches
// the beat and reads both 128-byte sector buffers (registered read); the execute step
// applies the command and loads the result register, waiting there while the previous
// result is still unclaimed. A new beat is taken only once the last one has executed. Both
// buffers read as zero after reset and after a soft reset; no clearing pass is needed.
// Depends on fdc_pkg, fdc_if, fdc_ctrl and fdc_dp.
module floppy_controller_command_port
    import fdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fdc_item_if.sink          item,
    fdc_result_if.source      result,
    input  logic              wr_en,
    input  regidx_t           reg_index,
    input  mask_t             wr_data
);

    ctl_t ctl;

    fdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .ctl       (ctl)
    );

    fdc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .wr_en         (wr_en),
        .reg_index     (reg_index),
        .wr_data       (wr_data),
        .cmd           (item.cmd),
        .data          (item.data),
        .byte_index    (item.byte_index),
        .read_data     (result.read_data),
        .media_request (result.media_request),
        .media_drive   (result.media_drive),
        .media_sector  (result.media_sector)
    );

endmodule
